@@ hw/rtl/gff_pkg.sv @@
// ----------------------------------------------------------------------------
// gff_pkg
// Shared types and constants for the gateway frame filter and throttle.
// ----------------------------------------------------------------------------
package gff_pkg;

  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [7:0] CmdLanOnly = 8'h23;
  localparam logic [7:0] CmdPing    = 8'h31;
  localparam logic [7:0] CmdQuery   = 8'h0C;
  localparam logic [7:0] CmdSpeed   = 8'h08;
  localparam logic [7:0] PingMark   = 8'hEE;
  localparam logic [7:0] LenQuery   = 8'd5;
  localparam logic [7:0] LenSpeed   = 8'd6;

  localparam logic [1:0] VerdictForward   = 2'd0;
  localparam logic [1:0] VerdictLanOnly   = 2'd1;
  localparam logic [1:0] VerdictBlocked   = 2'd2;
  localparam logic [1:0] VerdictThrottled = 2'd3;

  localparam logic [31:0] MinIntervalReset = 32'd100;

  typedef struct packed {
    logic load;
    logic match;
    logic lookup;
    logic decide;
  } gff_cmd_t;

  typedef struct packed {
    logic out_free;
  } gff_stat_t;

endpackage

@@ hw/rtl/gateway_frame_filter_throttle.sv @@
// ----------------------------------------------------------------------------
// gateway_frame_filter_throttle
// Filters LAN-to-CAN gateway frames and rate limits speed commands per loco.
// ----------------------------------------------------------------------------
// Each accepted word is captured, its address is compared against every
// stored entry, the lowest matching entry is picked and its time read from
// the time store (held there while the result register is still full), and
// a 32-bit add and compare decides the verdict and writes the table. A new
// word is taken while the previous result still waits; one frame is worked
// on at a time. The table needs no clearing pass after reset; its fill count
// marks which entries are in use.
module gateway_frame_filter_throttle #(
  parameter int unsigned LOCO_ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // can_id[31:0], length_code[39:32], payload[103:40], now_ms[135:104]
  input  logic [gff_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // verdict[1:0], ping_reply[2], table_full[3], zero fill [7:4]
  output logic [gff_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gff_pkg::ApbAddrW-1:0]      paddr,
  input  logic [gff_pkg::ApbDataW-1:0]      pwdata,
  output logic [gff_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);
  import gff_pkg::*;

  gff_cmd_t    cmd;
  gff_stat_t   stat;
  logic [31:0] min_interval_q;
  logic        reg_sel;
  logic [1:0]  verdict;
  logic        ping_reply, table_full;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ApbAddrW-1] == 1'b0);
  assign prdata  = reg_sel ? min_interval_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q <= MinIntervalReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      min_interval_q <= pwdata;
    end
  end

  gff_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  gff_datapath #(
    .LOCO_ENTRIES (LOCO_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .can_id_i       (s_axis_tdata[31:0]),
    .length_code_i  (s_axis_tdata[39:32]),
    .payload_i      (s_axis_tdata[103:40]),
    .now_ms_i       (s_axis_tdata[135:104]),
    .min_interval_i (min_interval_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .verdict_o      (verdict),
    .ping_reply_o   (ping_reply),
    .table_full_o   (table_full)
  );

  assign m_axis_tdata = {4'b0000, table_full, ping_reply, verdict};

endmodule

@@ hw/rtl/gff_ctrl.sv @@
// ----------------------------------------------------------------------------
// gff_ctrl
// Sequencer that steps one frame through capture, match, lookup and decision.
// ----------------------------------------------------------------------------
module gff_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  gff_pkg::gff_stat_t stat_i,
  output gff_pkg::gff_cmd_t  cmd_o
);
  import gff_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_LOOKUP = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (stat_i.out_free) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/gff_datapath.sv @@
// ----------------------------------------------------------------------------
// gff_datapath
// Frame registers, locomotive address match, time store and result register.
// ----------------------------------------------------------------------------
module gff_datapath #(
  parameter int unsigned LOCO_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gff_pkg::gff_cmd_t  cmd_i,
  output gff_pkg::gff_stat_t stat_o,
  input  logic [31:0]        can_id_i,
  input  logic [7:0]         length_code_i,
  input  logic [63:0]        payload_i,
  input  logic [31:0]        now_ms_i,
  input  logic [31:0]        min_interval_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         verdict_o,
  output logic               ping_reply_o,
  output logic               table_full_o
);
  import gff_pkg::*;

  localparam int unsigned IdxW = (LOCO_ENTRIES > 1) ? $clog2(LOCO_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(LOCO_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(LOCO_ENTRIES);

  logic [31:0] id_q, now_q;
  logic [7:0]  len_q;
  logic [63:0] payload_q;

  logic [31:0] addr_q [LOCO_ENTRIES];
  logic [31:0] time_mem [LOCO_ENTRIES];
  logic [31:0] time_rd_q;

  logic [CntW-1:0]         count_q;
  logic [LOCO_ENTRIES-1:0] match_q, match_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic                    found_q;

  logic                    out_valid_q;
  logic [1:0]              verdict_q, verdict_d;
  logic                    ping_q, ping_d, full_q, full_d;

  logic [7:0]  cmd_code;
  logic [31:0] loco_addr;
  logic [31:0] due;
  logic        is_speed, do_update, do_insert;

  assign cmd_code  = id_q[23:16];
  assign loco_addr = payload_q[63:32];
  assign due       = time_rd_q + min_interval_i;
  assign is_speed  = (cmd_code == CmdSpeed) && (len_q == LenSpeed) &&
                     ((payload_q[31:24] | payload_q[23:16]) != 8'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q      <= can_id_i;
      len_q     <= length_code_i;
      payload_q <= payload_i;
      now_q     <= now_ms_i;
    end
  end

  always_comb begin
    for (int i = 0; i < LOCO_ENTRIES; i++) begin
      match_d[i] = (CntW'(i) < count_q) && (addr_q[i] == loco_addr);
    end
  end

  always_comb begin
    idx_d = '0;
    for (int i = LOCO_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        idx_d = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (cmd_i.match) begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      idx_q     <= idx_d;
      found_q   <= |match_q;
      time_rd_q <= time_mem[idx_d];
    end
  end

  always_comb begin
    verdict_d = VerdictForward;
    ping_d    = 1'b0;
    full_d    = 1'b0;
    do_update = 1'b0;
    do_insert = 1'b0;
    if (cmd_code == CmdLanOnly) begin
      verdict_d = VerdictLanOnly;
    end else begin
      ping_d = (cmd_code == CmdPing) && (payload_q[15:8] == PingMark) &&
               (payload_q[7:0] == PingMark);
      if ((cmd_code == CmdQuery) && (len_q == LenQuery)) begin
        verdict_d = VerdictBlocked;
      end else if (is_speed) begin
        if (found_q) begin
          if (due < now_q) begin
            do_update = 1'b1;
          end else begin
            verdict_d = VerdictThrottled;
          end
        end else if (count_q < CntMax) begin
          do_insert = 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && do_update) begin
      time_mem[idx_q] <= now_q;
    end else if (cmd_i.decide && do_insert) begin
      time_mem[count_q[IdxW-1:0]] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && do_insert) begin
      addr_q[count_q[IdxW-1:0]] <= loco_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.decide && do_insert) begin
      count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      verdict_q <= verdict_d;
      ping_q    <= ping_d;
      full_q    <= full_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign verdict_o       = verdict_q;
  assign ping_reply_o    = ping_q;
  assign table_full_o    = full_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("entry count exceeds table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match_q))
    else $error("locomotive address stored in more than one entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(cmd_i.decide))
    else $error("entry count changed outside a decision");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule
